>>> sv/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// shared types and constants of the bitmap frame allocator
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned CFG_IDX_W  = 1;

  // operation codes
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_REJECTED  = 2'd2,
    STAT_NOCHANGE  = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 1'b0,
    REG_FRAME_COUNT  = 1'b1
  } cfg_reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_ALLOC_RD,
    S_ALLOC_CHK,
    S_UPD_RD,
    S_UPD_CHK,
    S_CLEAR,
    S_DONE
  } state_e;

  // word evaluation result
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] first_idx;
    logic             bit_val;
  } eval_t;

endpackage

>>> sv/bfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bfa_bitmap_ram
// single write port, single registered read port bitmap word store
// ----------------------------------------------------------------------------
module bfa_bitmap_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [bfa_pkg::WORD_W-1:0]  wr_data_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [bfa_pkg::WORD_W-1:0]  rd_data_o
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> sv/bfa_word_eval.sv
// ----------------------------------------------------------------------------
// bfa_word_eval
// shared word unit: first free bit search, bit test and word update
// ----------------------------------------------------------------------------
module bfa_word_eval (
  input  logic [bfa_pkg::WORD_W-1:0] word_i,
  input  logic [bfa_pkg::WORD_W-1:0] mask_i,
  input  logic [bfa_pkg::BIT_W-1:0]  bit_idx_i,
  input  logic                       alloc_i,
  input  logic                       set_i,
  output bfa_pkg::eval_t             res_o,
  output logic [bfa_pkg::WORD_W-1:0] word_o
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] free_vec;
  logic [BIT_W-1:0]  first;
  logic [WORD_W-1:0] sel;

  assign free_vec = ~word_i & mask_i;

  // lowest free bit wins
  always_comb begin
    first = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        first = BIT_W'(i);
      end
    end
  end

  assign sel = alloc_i ? (WORD_W'(1) << first) : (WORD_W'(1) << bit_idx_i);

  always_comb begin
    res_o.found     = |free_vec;
    res_o.first_idx = first;
    res_o.bit_val   = word_i[bit_idx_i];
    if (alloc_i || set_i) begin
      word_o = word_i | sel;
    end else begin
      word_o = word_i & ~sel;
    end
  end

endmodule

>>> sv/bitmap_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_core
// first fit page frame allocator, one used bit per 4 KB frame
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// cfg     | in  | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
// in      | in  | in_valid/in_stall   | operation_i, address_i
// out     | out | out_valid/out_stall | frame_address_o, status_o, free_frames_o
//
// steps: allocate reads and checks one word at a time (S_ALLOC_RD then
//   S_ALLOC_CHK) up to the last managed word; free and reserve pass
//   S_UPD_RD, S_UPD_CHK; clear zeroes every word; each ends in S_DONE.
// the scan is paced by the single registered read port of the bitmap ram
// reset: a clearing pass writes every bitmap word to zero, one word a cycle
//   (1024 words by default), no beat accepted; one beat at a time; the
//   result register lets the next beat in while the previous result is stalled
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_core #(
  parameter int unsigned MAX_FRAMES_HELD = 32768
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  // request
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     operation_i,
  input  logic [31:0]                    address_i,
  // result
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    frame_address_o,
  output bfa_pkg::status_e               status_o,
  output logic [15:0]                    free_frames_o
);
  import bfa_pkg::*;

  localparam int unsigned NW = (MAX_FRAMES_HELD + WORD_W - 1) / WORD_W;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES_HELD + 1);

  // configuration registers
  logic [31:0] base_q;
  logic [15:0] fcount_q;

  // sequencer and datapath state
  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [AW-1:0]     word_q, word_d;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [31:0]       res_addr_q, res_addr_d;
  status_e           res_stat_q, res_stat_d;
  logic [CW-1:0]     used_q, used_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_addr_q, out_addr_d;
  status_e           out_stat_q, out_stat_d;
  logic [15:0]       out_free_q, out_free_d;

  // ram port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  // word unit
  eval_t             ev;
  logic [WORD_W-1:0] ev_word;
  logic [WORD_W-1:0] elig_mask;

  // derived values
  logic [15:0]       total;
  logic [15:0]       total_m1;
  logic [31:0]       base_al;
  logic [31:0]       addr_diff;
  logic [19:0]       addr_idx;
  logic              addr_ok;
  logic              addr_unaligned;
  logic              accept;
  logic              out_free_slot;
  logic              last_word;
  logic              sweep_last;
  logic [AW+BIT_W-1:0] alloc_idx;

  // ---------------------------------------------------------------------------
  // configuration port, always ready; writes must come only while idle, the block does not enforce it
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      fcount_q <= 16'h8000;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_BASE_ADDRESS: base_q   <= cfg_data_i;
        REG_FRAME_COUNT:  fcount_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // address checks and limits
  // ---------------------------------------------------------------------------
  // managed total clipped to the bitmap capacity
  assign total    = (32'(fcount_q) > 32'(MAX_FRAMES_HELD)) ? 16'(MAX_FRAMES_HELD) : fcount_q;
  assign total_m1 = total - 16'd1;
  assign base_al  = {base_q[31:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

  assign addr_diff      = address_i - base_al;
  assign addr_idx       = addr_diff[31:PAGE_SHIFT];
  assign addr_ok        = (address_i >= base_al) && (addr_idx < 20'(total));
  assign addr_unaligned = |address_i[PAGE_SHIFT-1:0];

  assign accept        = in_valid_i && !in_stall_o;
  assign out_free_slot = !out_valid_q || !out_stall_i;

  // scan stops at the word that holds the last managed frame
  assign last_word  = (32'(word_q) == 32'(total_m1[15:BIT_W]));
  assign sweep_last = (32'(word_q) == 32'(NW - 1));

  // frames at or above the total are never handed out
  assign elig_mask = (32'(word_q) == 32'(total[15:BIT_W]))
                   ? ((WORD_W'(1) << total[BIT_W-1:0]) - WORD_W'(1))
                   : '1;

  assign alloc_idx = {word_q, ev.first_idx};

  // ---------------------------------------------------------------------------
  // bitmap store and shared word unit
  // ---------------------------------------------------------------------------
  bfa_bitmap_ram #(
    .DEPTH (NW),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .re_i      (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  bfa_word_eval u_eval (
    .word_i    (ram_rdata),
    .mask_i    (elig_mask),
    .bit_idx_i (bit_q),
    .alloc_i   (op_q == OP_ALLOC),
    .set_i     (op_q == OP_RESERVE),
    .res_o     (ev),
    .word_o    (ev_word)
  );

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (sweep_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(operation_i))
            OP_ALLOC:   state_d = (total == 16'd0) ? S_DONE : S_ALLOC_RD;
            OP_FREE:    state_d = (addr_unaligned || !addr_ok) ? S_DONE : S_UPD_RD;
            OP_RESERVE: state_d = addr_ok ? S_UPD_RD : S_DONE;
            OP_CLEAR:   state_d = S_CLEAR;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_ALLOC_RD:  state_d = S_ALLOC_CHK;
      S_ALLOC_CHK: begin
        if (ev.found || last_word) state_d = S_DONE;
        else                       state_d = S_ALLOC_RD;
      end
      S_UPD_RD:  state_d = S_UPD_CHK;
      S_UPD_CHK: state_d = S_DONE;
      S_CLEAR: begin
        if (sweep_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free_slot) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // outputs and datapath
  // ---------------------------------------------------------------------------
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    op_d        = op_q;
    word_d      = word_q;
    bit_d       = bit_q;
    res_addr_d  = res_addr_q;
    res_stat_d  = res_stat_q;
    used_d      = used_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_addr_d  = out_addr_q;
    out_stat_d  = out_stat_q;
    out_free_d  = out_free_q;
    ram_we      = 1'b0;
    ram_waddr   = word_q;
    ram_wdata   = ev_word;
    ram_re      = 1'b0;
    ram_raddr   = word_q;

    unique case (state_q)
      S_INIT, S_CLEAR: begin
        // zero one word a cycle
        ram_we    = 1'b1;
        ram_wdata = '0;
        word_d    = word_q + AW'(1);
        if (sweep_last) begin
          used_d = '0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d       = op_e'(operation_i);
          word_d     = '0;
          bit_d      = addr_idx[BIT_W-1:0];
          res_addr_d = '0;
          res_stat_d = STAT_DONE;
          unique case (op_e'(operation_i))
            OP_ALLOC: begin
              if (total == 16'd0) res_stat_d = STAT_EXHAUSTED;
            end
            OP_FREE: begin
              word_d = addr_idx[AW+BIT_W-1:BIT_W];
              if (addr_unaligned || !addr_ok) res_stat_d = STAT_REJECTED;
            end
            OP_RESERVE: begin
              word_d = addr_idx[AW+BIT_W-1:BIT_W];
              if (!addr_ok) res_stat_d = STAT_REJECTED;
            end
            default: ;
          endcase
        end
      end
      S_ALLOC_RD, S_UPD_RD: begin
        ram_re = 1'b1;
      end
      S_ALLOC_CHK: begin
        if (ev.found) begin
          ram_we     = 1'b1;
          used_d     = used_q + CW'(1);
          res_addr_d = base_al + (32'(alloc_idx) << PAGE_SHIFT);
        end else if (last_word) begin
          res_stat_d = STAT_EXHAUSTED;
        end else begin
          word_d = word_q + AW'(1);
        end
      end
      S_UPD_CHK: begin
        if (op_q == OP_FREE) begin
          if (!ev.bit_val) begin
            res_stat_d = STAT_NOCHANGE;
          end else begin
            ram_we = 1'b1;
            if (used_q != '0) used_d = used_q - CW'(1);
          end
        end else begin
          if (ev.bit_val) begin
            res_stat_d = STAT_NOCHANGE;
          end else begin
            ram_we = 1'b1;
            used_d = used_q + CW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free_slot) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_stat_d  = res_stat_q;
          // saturating free count
          out_free_d  = (32'(total) > 32'(used_q))
                      ? 16'(32'(total) - 32'(used_q)) : 16'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      word_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    bit_q      <= bit_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
    out_addr_q <= out_addr_d;
    out_stat_q <= out_stat_d;
    out_free_q <= out_free_d;
  end

  assign out_valid_o     = out_valid_q;
  assign frame_address_o = out_addr_q;
  assign status_o        = out_stat_q;
  assign free_frames_o   = out_free_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(MAX_FRAMES_HELD))
    else $error("used count above capacity");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_INIT || state_q == S_CLEAR ||
                state_q == S_ALLOC_CHK || state_q == S_UPD_CHK))
    else $error("bitmap written outside an update state");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after accepting a beat");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside done state");

  a_used_moves_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> ($past(state_q) == S_INIT ||
      $past(state_q) == S_CLEAR || $past(state_q) == S_ALLOC_CHK ||
      $past(state_q) == S_UPD_CHK))
    else $error("used count changed outside an update state");

endmodule

>>> tb/sv/tb_bitmap_frame_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator_core
// self-checking bench for the first fit bitmap frame allocator
// ----------------------------------------------------------------------------
// a directed table walks the corner cases with hand-written results, then
// random phases reprogram base address and frame count and mix allocate,
// free, reserve and clear beats; every random-phase result beat is checked against a
// bitmap model kept inside the bench, under several idle and stall patterns
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator_core;
  import bfa_pkg::*;

  localparam int unsigned MAP_FRAMES     = 32768;
  localparam logic [31:0] PAGE_MASK      = 32'h0000_0fff;
  localparam int          CLK_PERIOD     = 12;
  localparam int          RESET_CYCLES   = 7;
  // settle window, longer than the worst allocate scan
  localparam int          SETTLE_CYCLES  = 2100;
  localparam longint      TIMEOUT_CYCLES = 20_000_000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          MAX_PRINTED    = 100;

  // one result beat as the block should present it
  typedef struct packed {
    logic [31:0] page_addr;
    status_e     status;
    logic [15:0] free_cnt;
  } reply_t;

  // one row of the directed table: a register write or a request beat
  typedef struct {
    bit          is_cfg;
    cfg_reg_e    reg_sel;
    logic [31:0] value;
    op_e         op;
    reply_t      reply;
  } dir_row_t;

  // dut signals, all inputs known from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i = REG_BASE_ADDRESS;
  logic [31:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [31:0] address_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] frame_address_o;
  status_e     status_o;
  logic [15:0] free_frames_o;

  // bench-side copy of the allocator state
  bit          frame_used [MAP_FRAMES];
  int unsigned used_frames = 0;
  logic [31:0] base_reg    = '0;
  logic [15:0] count_reg   = 16'd32768;

  // results owed by the block, oldest first
  reply_t      replies_due [$];
  int unsigned mismatch_count = 0;

  // idle and stall knobs, percent per cycle
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  // long receiver hold-off, counted down in the stall process
  int          stall_hold   = 0;

  bitmap_frame_allocator_core #(
    .MAX_FRAMES_HELD(MAP_FRAMES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_address_o(frame_address_o),
    .status_o       (status_o),
    .free_frames_o  (free_frames_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // bitmap model
  // ---------------------------------------------------------------------------

  // frames reachable right now, frame count clamps at the map capacity
  function automatic int unsigned managed_frames();
    return (count_reg > MAP_FRAMES) ? MAP_FRAMES : int'(count_reg);
  endfunction

  // low 12 bits of the base register are ignored
  function automatic logic [31:0] page_base();
    return base_reg & ~PAGE_MASK;
  endfunction

  // apply one request to the model map and return the result it yields
  function automatic reply_t predict_frame_op(op_e op, logic [31:0] addr);
    reply_t      r;
    int unsigned total;
    int unsigned idx;
    int unsigned scan;
    bit          in_range;
    logic [31:0] offs;
    r.page_addr  = '0;
    r.status     = STAT_DONE;
    total        = managed_frames();
    offs         = addr - page_base();
    in_range     = (addr >= page_base()) && ((offs >> PAGE_SHIFT) < total);
    idx          = in_range ? (offs >> PAGE_SHIFT) : 0;
    case (op)
      OP_ALLOC: begin
        scan = 0;
        while (scan < total && frame_used[scan]) scan++;
        if (scan < total) begin
          frame_used[scan] = 1'b1;
          used_frames++;
          // wraps modulo 2^32 on purpose
          r.page_addr = page_base() + (scan << PAGE_SHIFT);
        end else begin
          r.status = STAT_EXHAUSTED;
        end
      end
      OP_FREE: begin
        if ((addr & PAGE_MASK) != 0 || !in_range) begin
          r.status = STAT_REJECTED;
        end else if (!frame_used[idx]) begin
          r.status = STAT_NOCHANGE;
        end else begin
          frame_used[idx] = 1'b0;
          if (used_frames > 0) used_frames--;
        end
      end
      OP_RESERVE: begin
        if (!in_range) begin
          r.status = STAT_REJECTED;
        end else if (frame_used[idx]) begin
          r.status = STAT_NOCHANGE;
        end else begin
          frame_used[idx] = 1'b1;
          used_frames++;
        end
      end
      default: begin
        foreach (frame_used[i]) frame_used[i] = 1'b0;
        used_frames = 0;
      end
    endcase
    // bits above a shrunk total still count, so saturate
    r.free_cnt = (total > used_frames) ? 16'(total - used_frames) : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic dir_row_t item_row(op_e op, logic [31:0] addr,
                                        logic [31:0] fa, status_e st,
                                        logic [15:0] ff);
    dir_row_t row;
    row.is_cfg          = 1'b0;
    row.reg_sel         = REG_BASE_ADDRESS;
    row.value           = addr;
    row.op              = op;
    row.reply.page_addr = fa;
    row.reply.status    = st;
    row.reply.free_cnt  = ff;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(cfg_reg_e sel, logic [31:0] value);
    dir_row_t row;
    row.is_cfg  = 1'b1;
    row.reg_sel = sel;
    row.value   = value;
    row.op      = OP_ALLOC;
    row.reply   = '0;
    return row;
  endfunction

  // random request, biased toward addresses near the frames in use
  task automatic pick_request(output op_e op, output logic [31:0] addr);
    int unsigned roll;
    int unsigned total;
    int unsigned hot;
    int unsigned idx;
    logic [31:0] base_m;
    roll   = $urandom_range(99, 0);
    total  = managed_frames();
    base_m = page_base();
    addr   = $urandom();
    if (roll < 42) begin
      op = OP_ALLOC;
    end else if (roll < 96) begin
      op = (roll < 72) ? OP_FREE : OP_RESERVE;
      case ($urandom_range(9, 0))
        0: ;  // fully random address
        1: addr = base_m - $urandom_range(32'h2000, 1);
        2: addr = base_m + ((total + $urandom_range(3, 0)) << PAGE_SHIFT);
        default: begin
          // first fit packs used frames low, so aim there mostly
          hot = used_frames + 4;
          if (hot > total) hot = total;
          idx = (hot == 0) ? 0 : $urandom_range(hot - 1, 0);
          if (total != 0 && $urandom_range(3, 0) == 0) idx = $urandom_range(total - 1, 0);
          addr = base_m + (idx << PAGE_SHIFT);
          if (op == OP_RESERVE) begin
            addr = addr + $urandom_range(32'hfff, 0);
          end else if ($urandom_range(4, 0) == 0) begin
            addr = addr + $urandom_range(32'hfff, 1);
          end
        end
      endcase
    end else begin
      op = OP_CLEAR;
    end
  endtask

  // hold the request side low until every owed result has come back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // one register write beat, only ever issued while the block is idle
  task automatic write_register(input cfg_reg_e sel, input logic [31:0] value);
    // back-to-back writes keep valid high, otherwise wait for idle first
    if (!cfg_valid_i) drain_replies();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (sel == REG_BASE_ADDRESS) begin
      base_reg = value;
    end else begin
      count_reg = value[15:0];
    end
  endtask

  // one request beat; the model is stepped at the accepting edge
  task automatic send_request(input op_e op, input logic [31:0] addr,
                              input bit use_typed, input reply_t typed_reply);
    reply_t predicted;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    if (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      // junk payload while idle
      in_valid_i  <= 1'b0;
      operation_i <= 2'($urandom_range(3, 0));
      address_i   <= $urandom();
      do @(posedge clk_i); while ($urandom_range(99, 0) < tx_idle_pct);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    address_i   <= addr;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_frame_op(op, addr);
    replies_due.push_back(use_typed ? typed_reply : predicted);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stall, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      out_stall_i <= 1'b1;
      stall_hold  <= stall_hold - 1;
    end else if (rx_stall_pct != 0) begin
      out_stall_i <= ($urandom_range(99, 0) < rx_stall_pct);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // result checker, field by field against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_reply
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        report_mismatch("result beat with nothing owed", frame_address_o, '0);
      end else begin
        want = replies_due.pop_front();
        if (frame_address_o !== want.page_addr) begin
          report_mismatch("frame_address", frame_address_o, want.page_addr);
        end
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
        if (free_frames_o !== want.free_cnt) begin
          report_mismatch("free_frames", 32'(free_frames_o), 32'(want.free_cnt));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t    rows [$];
    op_e         op;
    logic [31:0] addr;
    logic [31:0] base_val;
    logic [31:0] count_val;
    int unsigned n_items;

    // after reset: base 0, 32768 frames, map empty
    rows.push_back(item_row(OP_ALLOC,   32'h0000_0000, 32'h0000_0000, STAT_DONE, 16'd32767));
    rows.push_back(item_row(OP_ALLOC,   32'hffff_ffff, 32'h0000_1000, STAT_DONE, 16'd32766));
    rows.push_back(item_row(OP_FREE,    32'h0000_1000, 32'h0, STAT_DONE,     16'd32767));
    // free of a frame already free
    rows.push_back(item_row(OP_FREE,    32'h0000_1000, 32'h0, STAT_NOCHANGE, 16'd32767));
    // unaligned free
    rows.push_back(item_row(OP_FREE,    32'h0000_0801, 32'h0, STAT_REJECTED, 16'd32767));
    // first frame past the managed total
    rows.push_back(item_row(OP_FREE,    32'h0800_0000, 32'h0, STAT_REJECTED, 16'd32767));
    // last frame, reserved by its top byte, then again by an inner byte
    rows.push_back(item_row(OP_RESERVE, 32'h07ff_ffff, 32'h0, STAT_DONE,     16'd32766));
    rows.push_back(item_row(OP_RESERVE, 32'h07ff_f123, 32'h0, STAT_NOCHANGE, 16'd32766));
    rows.push_back(item_row(OP_FREE,    32'hffff_f000, 32'h0, STAT_REJECTED, 16'd32766));
    rows.push_back(item_row(OP_RESERVE, 32'hffff_ffff, 32'h0, STAT_REJECTED, 16'd32766));
    // lowest free is frame 1 again
    rows.push_back(item_row(OP_ALLOC,   32'h0,         32'h0000_1000, STAT_DONE, 16'd32765));
    rows.push_back(item_row(OP_CLEAR,   32'hffff_ffff, 32'h0, STAT_DONE,     16'd32768));
    // top-of-space base with low bits set, three frames; addresses wrap
    rows.push_back(cfg_row(REG_BASE_ADDRESS, 32'hffff_fabc));
    rows.push_back(cfg_row(REG_FRAME_COUNT,  32'h0000_0003));
    rows.push_back(item_row(OP_ALLOC,   32'h0, 32'hffff_f000, STAT_DONE,     16'd2));
    rows.push_back(item_row(OP_ALLOC,   32'h0, 32'h0000_0000, STAT_DONE,     16'd1));
    // below the base
    rows.push_back(item_row(OP_FREE,    32'h0000_0000, 32'h0, STAT_REJECTED, 16'd1));
    rows.push_back(item_row(OP_RESERVE, 32'h0000_0fff, 32'h0, STAT_REJECTED, 16'd1));
    rows.push_back(item_row(OP_ALLOC,   32'h0, 32'h0000_1000, STAT_DONE,     16'd0));
    // nothing free
    rows.push_back(item_row(OP_ALLOC,   32'h0, 32'h0, STAT_EXHAUSTED,        16'd0));
    rows.push_back(item_row(OP_FREE,    32'hffff_f000, 32'h0, STAT_DONE,     16'd1));
    // shrink to one frame: frames 1 and 2 stay used, count saturates
    rows.push_back(cfg_row(REG_FRAME_COUNT,  32'h0000_0001));
    rows.push_back(item_row(OP_ALLOC,   32'h0, 32'hffff_f000, STAT_DONE,     16'd0));
    rows.push_back(item_row(OP_ALLOC,   32'h0, 32'h0, STAT_EXHAUSTED,        16'd0));
    // no frames managed at all
    rows.push_back(cfg_row(REG_FRAME_COUNT,  32'h0000_0000));
    rows.push_back(item_row(OP_ALLOC,   32'h0, 32'h0, STAT_EXHAUSTED,        16'd0));
    rows.push_back(item_row(OP_RESERVE, 32'hffff_f000, 32'h0, STAT_REJECTED, 16'd0));
    // count above capacity clamps; the old used frames come back into view
    rows.push_back(cfg_row(REG_FRAME_COUNT,  32'hffff_ffff));
    rows.push_back(item_row(OP_ALLOC,   32'h0, 32'h0000_2000, STAT_DONE,     16'd32764));
    rows.push_back(item_row(OP_CLEAR,   32'h0, 32'h0, STAT_DONE,             16'd32768));

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, no idling; the clearing pass is absorbed by in_stall_o
    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        write_register(rows[k].reg_sel, rows[k].value);
      end else begin
        send_request(rows[k].op, rows[k].value, 1'b1, rows[k].reply);
      end
    end

    // random phases, each with its own register setting and idle pattern
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 63; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 63; end
        default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
      endcase
      base_val  = $urandom();
      count_val = {16'($urandom()), 16'($urandom_range(120, 2))};
      n_items   = 160;
      case (phase)
        0: begin base_val = 32'h0; count_val = 32'h0000_8000; n_items = 60; end
        1: begin base_val = 32'hffff_f000; count_val = 32'h0000_0028; n_items = 130; end
        2: begin count_val = {16'($urandom()), 16'd0}; n_items = 40; end
        3: begin count_val = {16'($urandom()), 16'd1}; n_items = 80; end
        4: begin count_val = 32'hffff_ffff; n_items = 60; end
        5: begin base_val = 32'hffff_ffff; count_val = {16'($urandom()), 16'd64}; n_items = 130; end
        default: ;
      endcase
      write_register(REG_BASE_ADDRESS, base_val);
      write_register(REG_FRAME_COUNT, count_val);
      // receiver goes quiet for a while, the request side keeps pushing
      if (phase == 6) stall_hold <= HOLD_CYCLES;
      for (int unsigned n = 0; n < n_items; n++) begin
        // sender pauses mid-phase until the block has answered everything
        if (phase == 7 && n == 70) drain_replies();
        pick_request(op, addr);
        send_request(op, addr, 1'b0, '0);
      end
    end

    // let the last results out, then watch for stray beats
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("Verification failed");
    $finish;
  end

endmodule
